[hdl/ctli_pkg.sv]
// ----------------------------------------------------------------------------
// Connection table package
// Shared types and constants for the connection table block.
// ----------------------------------------------------------------------------
package ctli_pkg;

  localparam int unsigned Buckets = 64;
  localparam int unsigned Entries = 64;
  localparam int unsigned BucketW = $clog2(Buckets);
  localparam int unsigned SlotW = $clog2(Entries);
  localparam int unsigned LinkW = SlotW + 1;
  localparam int unsigned HandleW = 6;
  localparam int unsigned PortShift = 16;
  localparam logic [LinkW-1:0] NoneSlot = LinkW'(Entries);

  typedef enum logic [1:0] {
    StatusOk = 2'd0,
    StatusFull = 2'd1,
    StatusUnused = 2'd2
  } status_e;

  typedef struct packed {
    logic action;
    logic [31:0] remote_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [HandleW-1:0] release_handle;
  } req_t;

  typedef struct packed {
    logic [HandleW-1:0] entry_handle;
    logic created;
    logic [1:0] status;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StHead,
    StWalk,
    StScan,
    StInsert,
    StRelRead,
    StRelLink,
    StOut
  } state_e;

  function automatic logic [BucketW-1:0] bucket_of(logic [31:0] addr, logic [15:0] sp,
                                                   logic [15:0] dp);
    logic [31:0] sum;
    sum = addr + {sp, 16'h0} + {16'h0, dp};
    return sum[BucketW-1:0];
  endfunction

endpackage

[hdl/ctli_if.sv]
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one word of a given payload type with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ctli_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/connection_table_lookup_insert.sv]
// ----------------------------------------------------------------------------
// Connection table lookup and insert
// Chained hash table of connections with lookup, insert and release.
// ----------------------------------------------------------------------------
// Channel  Dir  Word
// req_i    in   action, remote_addr, src_port, dst_port, release_handle
// rsp_o    out  entry_handle, created, status
//
// A lookup reads the bucket head, then walks the chain one entry at a time, reading
// each entry from the slot memory. A miss goes on to a free-slot search that scans
// the pool slots in order, then inserts into the first free slot or, on a full pool, reports full.
// A release reads the slot's links, then unlinks it, or reports it unused when the slot is not
// in use.
// Reset clears bucket heads and slot use flags through valid bits at once.
// A new word is taken only once the previous result has been delivered.
module connection_table_lookup_insert (
  input logic clk_i,
  input logic rst_ni,
  ctli_if.sink req_i,
  ctli_if.source rsp_o
);
  import ctli_pkg::*;

  logic [LinkW-1:0] head_mem [Buckets];
  logic [Buckets-1:0] head_vld_q;
  logic [63:0] key_mem [Entries];
  logic [LinkW-1:0] next_mem [Entries];
  logic [LinkW-1:0] prev_mem [Entries];
  logic [Entries-1:0] used_q, used_d;
  logic [Buckets-1:0] head_vld_d;

  state_e state_q, state_d;
  req_t req_q, req_d;
  rsp_t rsp_q, rsp_d;
  logic [LinkW-1:0] cur_q, cur_d, tail_q, tail_d;
  logic [SlotW:0] steps_q, steps_d, scan_q, scan_d;
  logic [BucketW-1:0] bkt_q, bkt_d;

  logic [LinkW-1:0] head_rd_q;
  logic [63:0] key_rd_q;
  logic [LinkW-1:0] next_rd_q, prev_rd_q;

  logic head_we, key_we, next_we, prev_we, next2_we;
  logic [BucketW-1:0] head_wa, head_ra;
  logic [LinkW-1:0] head_wd;
  logic [SlotW-1:0] key_wa, next_wa, prev_wa, rd_a, next2_wa;
  logic [LinkW-1:0] next_wd, prev_wd, next2_wd;
  logic [63:0] key_wd;
  logic [63:0] req_key;
  logic [LinkW-1:0] head_val;

  assign req_key = {req_q.remote_addr, req_q.src_port, req_q.dst_port};
  assign head_val = head_vld_q[bkt_q] ? head_rd_q : NoneSlot;

  always_ff @(posedge clk_i) begin
    head_rd_q <= head_mem[head_ra];
    key_rd_q <= key_mem[rd_a];
    next_rd_q <= next_mem[rd_a];
    prev_rd_q <= prev_mem[rd_a];
    if (head_we) head_mem[head_wa] <= head_wd;
    if (key_we) key_mem[key_wa] <= key_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next2_we) next_mem[next2_wa] <= next2_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_vld_q <= '0;
      used_q <= '0;
    end else begin
      state_q <= state_d;
      head_vld_q <= head_vld_d;
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
    cur_q <= cur_d;
    tail_q <= tail_d;
    steps_q <= steps_d;
    scan_q <= scan_d;
    bkt_q <= bkt_d;
  end

  assign req_i.ready = (state_q == StIdle);
  assign rsp_o.valid = (state_q == StOut);
  assign rsp_o.data = rsp_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (req_i.valid) state_d = req_i.data.action ? StRelRead : StHead;
      end
      StHead: state_d = StWalk;
      StWalk: begin
        if (cur_q == NoneSlot || steps_q == (SlotW + 1)'(Entries)) state_d = StScan;
        else if (key_rd_q == req_key) state_d = StOut;
      end
      StScan: begin
        if (scan_q == (SlotW + 1)'(Entries)) state_d = StOut;
        else if (!used_q[scan_q[SlotW-1:0]]) state_d = StInsert;
      end
      StInsert: state_d = StOut;
      StRelRead: begin
        if (!used_q[req_q.release_handle[SlotW-1:0]]) state_d = StOut;
        else state_d = StRelLink;
      end
      StRelLink: state_d = StOut;
      StOut: if (rsp_o.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    req_d = req_q;
    rsp_d = rsp_q;
    cur_d = cur_q;
    tail_d = tail_q;
    steps_d = steps_q;
    scan_d = scan_q;
    bkt_d = bkt_q;
    used_d = used_q;
    head_vld_d = head_vld_q;
    head_ra = bkt_q;
    rd_a = cur_q[SlotW-1:0];
    head_we = 1'b0; head_wa = bkt_q; head_wd = NoneSlot;
    key_we = 1'b0; key_wa = '0; key_wd = req_key;
    next_we = 1'b0; next_wa = '0; next_wd = NoneSlot;
    next2_we = 1'b0; next2_wa = '0; next2_wd = NoneSlot;
    prev_we = 1'b0; prev_wa = '0; prev_wd = NoneSlot;
    unique case (state_q)
      StIdle: begin
        req_d = req_i.data;
        bkt_d = bucket_of(req_i.data.remote_addr, req_i.data.src_port,
                          req_i.data.dst_port);
        head_ra = bkt_d;
        rd_a = req_i.data.release_handle[SlotW-1:0];
        tail_d = NoneSlot;
        steps_d = '0;
        scan_d = '0;
      end
      StHead: begin
        cur_d = head_val;
        rd_a = head_val[SlotW-1:0];
      end
      StWalk: begin
        if (cur_q == NoneSlot || steps_q == (SlotW + 1)'(Entries)) begin
          rsp_d = '{entry_handle: '0, created: 1'b0, status: StatusFull};
        end else if (key_rd_q == req_key) begin
          rsp_d = '{entry_handle: HandleW'(cur_q), created: 1'b0, status: StatusOk};
        end else begin
          tail_d = cur_q;
          cur_d = next_rd_q;
          rd_a = next_rd_q[SlotW-1:0];
          steps_d = steps_q + 1'b1;
        end
      end
      StScan: begin
        if (scan_q != (SlotW + 1)'(Entries) && !used_q[scan_q[SlotW-1:0]]) begin
          cur_d = LinkW'(scan_q);
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      StInsert: begin
        used_d[cur_q[SlotW-1:0]] = 1'b1;
        key_we = 1'b1; key_wa = cur_q[SlotW-1:0];
        next_we = 1'b1; next_wa = cur_q[SlotW-1:0]; next_wd = NoneSlot;
        prev_we = 1'b1; prev_wa = cur_q[SlotW-1:0]; prev_wd = tail_q;
        if (tail_q != NoneSlot) begin
          next2_we = 1'b1; next2_wa = tail_q[SlotW-1:0]; next2_wd = cur_q;
        end else begin
          head_we = 1'b1; head_wd = cur_q; head_vld_d[bkt_q] = 1'b1;
        end
        rsp_d = '{entry_handle: HandleW'(cur_q), created: 1'b1, status: StatusOk};
      end
      StRelRead: begin
        rd_a = req_q.release_handle[SlotW-1:0];
        rsp_d = '{entry_handle: req_q.release_handle, created: 1'b0,
                  status: StatusUnused};
        bkt_d = bucket_of(key_rd_q[63:32], key_rd_q[31:16], key_rd_q[15:0]);
      end
      StRelLink: begin
        if (next_rd_q != NoneSlot) begin
          prev_we = 1'b1; prev_wa = next_rd_q[SlotW-1:0]; prev_wd = prev_rd_q;
        end
        if (prev_rd_q != NoneSlot) begin
          next_we = 1'b1; next_wa = prev_rd_q[SlotW-1:0]; next_wd = next_rd_q;
        end else begin
          head_we = 1'b1; head_wd = next_rd_q; head_vld_d[bkt_q] = 1'b1;
        end
        used_d[req_q.release_handle[SlotW-1:0]] = 1'b0;
        rsp_d = '{entry_handle: req_q.release_handle, created: 1'b0, status: StatusOk};
      end
      StOut: ;
      default: ;
    endcase
  end

endmodule
